[rtl/core/mmic_pkg.sv]
// Shared types and constants for the magnetometer min/max iron calibration block.
package mmic_pkg;

  localparam int unsigned SAMPLE_BITS_DEF     = 16;
  localparam int unsigned SCALE_FRAC_BITS_DEF = 12;

  localparam int unsigned SCALE_W = 16;
  localparam logic [SCALE_W-1:0] SCALE_MAX = {SCALE_W{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } mmic_state_e;

  typedef struct packed {
    logic start;
    logic step;
  } div_ctrl_t;

endpackage

[rtl/core/mmic_extrema.sv]
// Running maximum and minimum of one axis, with its range and hard-iron offset.
module mmic_extrema #(
  parameter int unsigned SAMPLE_BITS = mmic_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   upd_i,
  input  logic                   restart_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic [SAMPLE_BITS-1:0] range_o,
  output logic [SAMPLE_BITS:0]   offset_o
);
  import mmic_pkg::*;

  logic [SAMPLE_BITS-1:0] max_q, max_d;
  logic [SAMPLE_BITS-1:0] min_q, min_d;
  logic [SAMPLE_BITS-1:0] base_max, base_min;
  logic [SAMPLE_BITS:0]   max_x, min_x;

  // restart clears the extrema before the sample is compared
  assign base_max = restart_i ? '0 : max_q;
  assign base_min = restart_i ? '0 : min_q;

  always_comb begin
    max_d = max_q;
    min_d = min_q;
    if (upd_i) begin
      max_d = ($signed(sample_i) > $signed(base_max)) ? sample_i : base_max;
      min_d = ($signed(sample_i) < $signed(base_min)) ? sample_i : base_min;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= '0;
      min_q <= '0;
    end else begin
      max_q <= max_d;
      min_q <= min_d;
    end
  end

  assign max_x = {max_q[SAMPLE_BITS-1], max_q};
  assign min_x = {min_q[SAMPLE_BITS-1], min_q};

  // max >= 0 >= min, so the range always fits SAMPLE_BITS unsigned bits
  assign range_o  = max_q - min_q;
  assign offset_o = max_x + min_x;

endmodule

[rtl/core/mmic_div_lane.sv]
// Bit-serial restoring divider lane: (total << frac) / (3 * range), saturated.
module mmic_div_lane #(
  parameter int unsigned SAMPLE_BITS     = mmic_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned SCALE_FRAC_BITS = mmic_pkg::SCALE_FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  mmic_pkg::div_ctrl_t       ctrl_i,
  input  logic [SAMPLE_BITS+1:0]    total_i,
  input  logic [SAMPLE_BITS-1:0]    range_i,
  output logic [mmic_pkg::SCALE_W-1:0] scale_o
);
  import mmic_pkg::*;

  localparam int unsigned TW = SAMPLE_BITS + 2;
  localparam int unsigned NW = TW + SCALE_FRAC_BITS;

  logic [NW-1:0]      dvd_q, dvd_d;
  logic [TW-1:0]      dvs_q, dvs_d;
  logic [TW-1:0]      rem_q, rem_d;
  logic [SCALE_W-1:0] quo_q, quo_d;
  logic               ovf_q, ovf_d;
  logic [TW:0]        trial;
  logic [TW:0]        diff;
  logic               qbit;

  assign trial = {rem_q, dvd_q[NW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign qbit  = !diff[TW];

  always_comb begin
    dvd_d = dvd_q;
    dvs_d = dvs_q;
    rem_d = rem_q;
    quo_d = quo_q;
    ovf_d = ovf_q;
    if (ctrl_i.start) begin
      dvd_d = {total_i, {SCALE_FRAC_BITS{1'b0}}};
      dvs_d = {1'b0, range_i, 1'b0} + {2'b00, range_i};
      rem_d = '0;
      quo_d = '0;
      ovf_d = 1'b0;
    end else if (ctrl_i.step) begin
      dvd_d = {dvd_q[NW-2:0], 1'b0};
      rem_d = qbit ? diff[TW-1:0] : trial[TW-1:0];
      // a quotient bit pushed past the top means the scale saturates
      ovf_d = ovf_q | quo_q[SCALE_W-1];
      quo_d = {quo_q[SCALE_W-2:0], qbit};
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    ovf_q <= ovf_d;
  end

  assign scale_o = ovf_q ? SCALE_MAX : quo_q;

endmodule

[rtl/core/mag_min_max_iron_calibration.sv]
// Each word is one three-axis sample; the block folds it into per-axis running
// extrema (both starting at zero, cleared first when restart is set) and returns
// one result word with offsets max+min and soft-iron scales
// floor(2^SCALE_FRAC_BITS*(dx+dy+dz)/(3*d)), saturated, zero for a zero-range axis.
// From acceptance, a sample goes through these steps: the extrema update on the
// accepting edge, the dividers are loaded, three restoring divider lanes each
// retire one quotient bit per cycle until the quotient is done, and the result
// moves into the output register. One sample is in work at a time; the next
// one is taken the cycle after the result is loaded, so no new sample is taken
// until the last one is through. A finished result waits in the output register
// while the next sample is accepted; a result still unread there holds the block
// in its last step until the output side takes it.
module mag_min_max_iron_calibration #(
  parameter int unsigned SAMPLE_BITS     = mmic_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned SCALE_FRAC_BITS = mmic_pkg::SCALE_FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [SAMPLE_BITS-1:0]       sample_x_i,
  input  logic [SAMPLE_BITS-1:0]       sample_y_i,
  input  logic [SAMPLE_BITS-1:0]       sample_z_i,
  input  logic                         restart_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [SAMPLE_BITS:0]         offset_x_o,
  output logic [SAMPLE_BITS:0]         offset_y_o,
  output logic [SAMPLE_BITS:0]         offset_z_o,
  output logic [mmic_pkg::SCALE_W-1:0] scale_x_o,
  output logic [mmic_pkg::SCALE_W-1:0] scale_y_o,
  output logic [mmic_pkg::SCALE_W-1:0] scale_z_o,
  output logic [2:0]                   degenerate_axes_o
);
  import mmic_pkg::*;

  localparam int unsigned TW    = SAMPLE_BITS + 2;
  localparam int unsigned NW    = TW + SCALE_FRAC_BITS;
  localparam int unsigned CNT_W = $clog2(NW);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NW - 1);

  mmic_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  div_ctrl_t div_ctrl;
  logic accept, out_load;

  logic [SAMPLE_BITS-1:0] range_x, range_y, range_z;
  logic [SAMPLE_BITS:0]   off_x, off_y, off_z;
  logic [TW-1:0]          total;
  logic [SCALE_W-1:0]     lscale_x, lscale_y, lscale_z;
  logic [2:0]             degen;

  logic                   out_valid_q, out_valid_d;
  logic [SAMPLE_BITS:0]   off_x_q, off_y_q, off_z_q;
  logic [SCALE_W-1:0]     scale_x_q, scale_y_q, scale_z_q;
  logic [2:0]             degen_q;

  assign accept = in_valid_i && in_ready_o;

  mmic_extrema #(.SAMPLE_BITS(SAMPLE_BITS)) u_ext_x (
    .clk_i, .rst_ni, .upd_i(accept), .restart_i,
    .sample_i(sample_x_i), .range_o(range_x), .offset_o(off_x)
  );
  mmic_extrema #(.SAMPLE_BITS(SAMPLE_BITS)) u_ext_y (
    .clk_i, .rst_ni, .upd_i(accept), .restart_i,
    .sample_i(sample_y_i), .range_o(range_y), .offset_o(off_y)
  );
  mmic_extrema #(.SAMPLE_BITS(SAMPLE_BITS)) u_ext_z (
    .clk_i, .rst_ni, .upd_i(accept), .restart_i,
    .sample_i(sample_z_i), .range_o(range_z), .offset_o(off_z)
  );

  assign total = {2'b00, range_x} + {2'b00, range_y} + {2'b00, range_z};

  mmic_div_lane #(.SAMPLE_BITS(SAMPLE_BITS), .SCALE_FRAC_BITS(SCALE_FRAC_BITS)) u_div_x (
    .clk_i, .ctrl_i(div_ctrl), .total_i(total), .range_i(range_x), .scale_o(lscale_x)
  );
  mmic_div_lane #(.SAMPLE_BITS(SAMPLE_BITS), .SCALE_FRAC_BITS(SCALE_FRAC_BITS)) u_div_y (
    .clk_i, .ctrl_i(div_ctrl), .total_i(total), .range_i(range_y), .scale_o(lscale_y)
  );
  mmic_div_lane #(.SAMPLE_BITS(SAMPLE_BITS), .SCALE_FRAC_BITS(SCALE_FRAC_BITS)) u_div_z (
    .clk_i, .ctrl_i(div_ctrl), .total_i(total), .range_i(range_z), .scale_o(lscale_z)
  );

  assign degen = {range_z == '0, range_y == '0, range_x == '0};

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        state_d = ST_DIV;
        cnt_d   = '0;
      end
      ST_DIV: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready_o     = 1'b0;
    div_ctrl.start = 1'b0;
    div_ctrl.step  = 1'b0;
    out_load       = 1'b0;
    case (state_q)
      ST_IDLE: in_ready_o     = 1'b1;
      ST_LOAD: div_ctrl.start = 1'b1;
      ST_DIV:  div_ctrl.step  = 1'b1;
      ST_DONE: out_load       = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load)         out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      off_x_q   <= off_x;
      off_y_q   <= off_y;
      off_z_q   <= off_z;
      scale_x_q <= degen[0] ? '0 : lscale_x;
      scale_y_q <= degen[1] ? '0 : lscale_y;
      scale_z_q <= degen[2] ? '0 : lscale_z;
      degen_q   <= degen;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign offset_x_o        = off_x_q;
  assign offset_y_o        = off_y_q;
  assign offset_z_o        = off_z_q;
  assign scale_x_o         = scale_x_q;
  assign scale_y_o         = scale_y_q;
  assign scale_z_o         = scale_z_q;
  assign degenerate_axes_o = degen_q;

`ifndef NO_ASSERTIONS
  // one sample in work at a time
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second word accepted while a sample is in work");

  // zero range means max = min = 0, so offset and scale are both zero
  a_degen_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_axes_o[0] |-> offset_x_o == '0 && scale_x_o == '0)
    else $error("degenerate x axis with nonzero offset or scale");

  a_degen_z: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_axes_o[2] |-> offset_z_o == '0 && scale_z_o == '0)
    else $error("degenerate z axis with nonzero offset or scale");

  // a new result only appears after the divider has finished
  a_result_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("result word raised outside of the done state");
`endif

endmodule
